### src/tcw_pkg.sv
// text console writer: shared constants, item and state types, cell helpers
// no dependencies
package tcw_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELL_COUNT  = COLUMNS * ROWS;
  localparam int COPY_COUNT  = COLUMNS * (ROWS - 1);
  localparam int CELL_W      = 11;
  localparam int ROW_W       = 5;
  localparam int COL_W       = 7;
  localparam int DATA_W      = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'h0F;

  typedef enum logic [1:0] {
    OP_WRITE_CHAR = 2'd0,
    OP_END_LINE   = 2'd1,
    OP_CLEAR      = 2'd2,
    OP_READ_CELL  = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [7:0]        char_code;
    logic [7:0]        attr;
    logic [CELL_W-1:0] cell_index;
    logic              index_ok;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_FILL,
    ST_RESUME,
    ST_READ
  } state_t;

  typedef enum logic [1:0] {
    FK_INIT,
    FK_SCROLL,
    FK_LINE,
    FK_CLEAR
  } fill_kind_t;

  function automatic logic [DATA_W-1:0] make_cell(input logic [7:0] attr,
                                                 input logic [7:0] ch);
    return {attr, ch};
  endfunction

  function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return CELL_W'(row) * CELL_W'(COLUMNS) + CELL_W'(col);
  endfunction

endpackage

### src/tcw_front.sv
// text console writer front: takes command words and classifies them
// depends on tcw_pkg
module tcw_front (
  input  logic                      start,
  input  logic                      busy,
  input  logic [1:0]                in_func,
  input  logic [7:0]                in_char_code,
  input  logic [7:0]                in_attr,
  input  logic [tcw_pkg::CELL_W-1:0] in_cell_index,
  output logic                      push,
  output tcw_pkg::item_t            push_item
);

  always_comb begin
    push                 = start && !busy;
    push_item.op         = tcw_pkg::op_t'(in_func);
    push_item.char_code  = in_char_code;
    push_item.attr       = in_attr;
    push_item.cell_index = in_cell_index;
    push_item.index_ok   = (in_cell_index < tcw_pkg::CELL_W'(tcw_pkg::CELL_COUNT));
  end

endmodule

### src/tcw_queue.sv
// text console writer command queue between front and back
// depends on tcw_pkg
module tcw_queue #(
  parameter int DEPTH = tcw_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tcw_pkg::item_t push_item,
  input  logic           pop,
  output tcw_pkg::item_t pop_item,
  output logic           empty,
  output logic           full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tcw_pkg::item_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    empty      = (count_r == '0);
    full       = (count_r == CNT_W'(DEPTH));
    do_push    = push && !full;
    do_pop     = pop && !empty;
    pop_item   = slot_r[rd_ptr_r];
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### src/tcw_back.sv
// text console writer back: cursor, screen memory and the scroll, fill and read sequencer
// depends on tcw_pkg
module tcw_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [7:0]                  default_attr,
  input  logic                        q_empty,
  input  tcw_pkg::item_t              q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  output logic [tcw_pkg::DATA_W-1:0]  out_cell_data,
  output logic [tcw_pkg::ROW_W-1:0]   out_cursor_row,
  output logic [tcw_pkg::COL_W-1:0]   out_cursor_column
);

  localparam logic [tcw_pkg::ROW_W-1:0]  ROWS_V    = tcw_pkg::ROW_W'(tcw_pkg::ROWS);
  localparam logic [tcw_pkg::COL_W-1:0]  COLS_V    = tcw_pkg::COL_W'(tcw_pkg::COLUMNS);
  localparam logic [tcw_pkg::CELL_W-1:0] CELLS_V   = tcw_pkg::CELL_W'(tcw_pkg::CELL_COUNT);
  localparam logic [tcw_pkg::CELL_W-1:0] COPY_V    = tcw_pkg::CELL_W'(tcw_pkg::COPY_COUNT);
  localparam logic [tcw_pkg::CELL_W-1:0] COLS_A    = tcw_pkg::CELL_W'(tcw_pkg::COLUMNS);

  logic [tcw_pkg::DATA_W-1:0] screen_mem [tcw_pkg::CELL_COUNT];

  tcw_pkg::state_t             state_r, state_nxt;
  tcw_pkg::fill_kind_t         fkind_r, fkind_nxt;
  tcw_pkg::op_t                op_r, op_nxt;
  logic [7:0]                  attr_r, attr_nxt;
  logic [tcw_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [tcw_pkg::COL_W-1:0]   col_r, col_nxt;
  logic [tcw_pkg::CELL_W-1:0]  addr_r, addr_nxt;
  logic [tcw_pkg::CELL_W-1:0]  end_r, end_nxt;
  logic [tcw_pkg::DATA_W-1:0]  fill_val_r, fill_val_nxt;
  logic                        wr_pend_r, wr_pend_nxt;
  logic [tcw_pkg::CELL_W-1:0]  wr_addr_r, wr_addr_nxt;
  logic [tcw_pkg::DATA_W-1:0]  rd_data_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [tcw_pkg::DATA_W-1:0]  out_data_r, out_data_nxt;
  logic [tcw_pkg::ROW_W-1:0]   out_row_r, out_row_nxt;
  logic [tcw_pkg::COL_W-1:0]   out_col_r, out_col_nxt;
  // character held for a write that waits on a scroll
  logic [7:0]                  rd_char_r;

  logic                        we;
  logic [tcw_pkg::CELL_W-1:0]  waddr;
  logic [tcw_pkg::DATA_W-1:0]  wdata;
  logic [tcw_pkg::CELL_W-1:0]  raddr;
  logic [tcw_pkg::ROW_W-1:0]   wc_row;
  logic [tcw_pkg::COL_W-1:0]   wc_col;
  logic [tcw_pkg::CELL_W-1:0]  addr_inc;

  always_comb begin
    state_nxt     = state_r;
    fkind_nxt     = fkind_r;
    op_nxt        = op_r;
    attr_nxt      = attr_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    addr_nxt      = addr_r;
    end_nxt       = end_r;
    fill_val_nxt  = fill_val_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    q_pop         = 1'b0;
    we            = wr_pend_r;
    waddr         = wr_addr_r;
    wdata         = rd_data_r;
    raddr         = addr_r + COLS_A;
    addr_inc      = addr_r + 1'b1;
    wc_row        = row_r;
    wc_col        = col_r;

    unique case (state_r)
      tcw_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          op_nxt   = q_item.op;
          attr_nxt = q_item.attr;
          unique case (q_item.op)
            tcw_pkg::OP_WRITE_CHAR: begin
              if (col_r >= COLS_V) begin
                wc_row = row_r + 1'b1;
                wc_col = '0;
              end
              if (wc_row >= ROWS_V) begin
                addr_nxt  = '0;
                state_nxt = tcw_pkg::ST_COPY;
              end else begin
                we            = 1'b1;
                waddr         = tcw_pkg::cell_addr(wc_row, wc_col);
                wdata         = tcw_pkg::make_cell(q_item.attr, q_item.char_code);
                row_nxt       = wc_row;
                col_nxt       = wc_col + 1'b1;
                out_valid_nxt = 1'b1;
                out_data_nxt  = '0;
                out_row_nxt   = wc_row;
                out_col_nxt   = wc_col + 1'b1;
              end
            end
            tcw_pkg::OP_END_LINE: begin
              if (row_r >= ROWS_V) begin
                addr_nxt  = '0;
                state_nxt = tcw_pkg::ST_COPY;
              end else if (col_r < COLS_V) begin
                addr_nxt     = tcw_pkg::cell_addr(row_r, col_r);
                end_nxt      = tcw_pkg::cell_addr(row_r, '0) + COLS_A;
                fill_val_nxt = tcw_pkg::make_cell(q_item.attr, tcw_pkg::BLANK_CHAR);
                fkind_nxt    = tcw_pkg::FK_LINE;
                state_nxt    = tcw_pkg::ST_FILL;
              end else begin
                row_nxt       = row_r + 1'b1;
                col_nxt       = '0;
                out_valid_nxt = 1'b1;
                out_data_nxt  = '0;
                out_row_nxt   = row_r + 1'b1;
                out_col_nxt   = '0;
              end
            end
            tcw_pkg::OP_CLEAR: begin
              addr_nxt     = '0;
              end_nxt      = CELLS_V;
              fill_val_nxt = tcw_pkg::make_cell(default_attr, tcw_pkg::BLANK_CHAR);
              fkind_nxt    = tcw_pkg::FK_CLEAR;
              state_nxt    = tcw_pkg::ST_FILL;
            end
            tcw_pkg::OP_READ_CELL: begin
              if (q_item.index_ok) begin
                raddr     = q_item.cell_index;
                state_nxt = tcw_pkg::ST_READ;
              end else begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '0;
                out_row_nxt   = row_r;
                out_col_nxt   = col_r;
              end
            end
            default: ;
          endcase
        end
      end
      tcw_pkg::ST_COPY: begin
        // read one row below, write it back in the next cycle
        if (addr_r < COPY_V) begin
          wr_pend_nxt = 1'b1;
          wr_addr_nxt = addr_r;
          addr_nxt    = addr_inc;
        end else begin
          addr_nxt     = COPY_V;
          end_nxt      = CELLS_V;
          fill_val_nxt = tcw_pkg::make_cell(default_attr, tcw_pkg::BLANK_CHAR);
          fkind_nxt    = tcw_pkg::FK_SCROLL;
          state_nxt    = tcw_pkg::ST_FILL;
        end
      end
      tcw_pkg::ST_FILL: begin
        we       = 1'b1;
        waddr    = addr_r;
        wdata    = fill_val_r;
        addr_nxt = addr_inc;
        if (addr_inc == end_r) begin
          unique case (fkind_r)
            tcw_pkg::FK_INIT: begin
              state_nxt = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::FK_CLEAR: begin
              row_nxt       = '0;
              col_nxt       = '0;
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              out_row_nxt   = '0;
              out_col_nxt   = '0;
              state_nxt     = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::FK_LINE: begin
              row_nxt       = row_r + 1'b1;
              col_nxt       = '0;
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              out_row_nxt   = row_r + 1'b1;
              out_col_nxt   = '0;
              state_nxt     = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::FK_SCROLL: begin
              row_nxt   = ROWS_V - 1'b1;
              col_nxt   = '0;
              state_nxt = tcw_pkg::ST_RESUME;
            end
            default: ;
          endcase
        end
      end
      tcw_pkg::ST_RESUME: begin
        if (op_r == tcw_pkg::OP_WRITE_CHAR) begin
          we            = 1'b1;
          waddr         = COPY_V;
          wdata         = tcw_pkg::make_cell(attr_r, rd_char_r);
          col_nxt       = tcw_pkg::COL_W'(1);
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_row_nxt   = row_r;
          out_col_nxt   = tcw_pkg::COL_W'(1);
          state_nxt     = tcw_pkg::ST_IDLE;
        end else begin
          addr_nxt     = COPY_V;
          end_nxt      = CELLS_V;
          fill_val_nxt = tcw_pkg::make_cell(attr_r, tcw_pkg::BLANK_CHAR);
          fkind_nxt    = tcw_pkg::FK_LINE;
          state_nxt    = tcw_pkg::ST_FILL;
        end
      end
      tcw_pkg::ST_READ: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = rd_data_r;
        out_row_nxt   = row_r;
        out_col_nxt   = col_r;
        state_nxt     = tcw_pkg::ST_IDLE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_FILL;
      fkind_r     <= tcw_pkg::FK_INIT;
      addr_r      <= '0;
      end_r       <= CELLS_V;
      fill_val_r  <= tcw_pkg::make_cell(tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR);
      row_r       <= '0;
      col_r       <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fkind_r     <= fkind_nxt;
      addr_r      <= addr_nxt;
      end_r       <= end_nxt;
      fill_val_r  <= fill_val_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    attr_r    <= attr_nxt;
    wr_addr_r <= wr_addr_nxt;
    out_data_r <= out_data_nxt;
    out_row_r <= out_row_nxt;
    out_col_r <= out_col_nxt;
    if (q_pop) begin
      rd_char_r <= q_item.char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      screen_mem[waddr] <= wdata;
    end
    rd_data_r <= screen_mem[raddr];
  end

  assign out_valid         = out_valid_r;
  assign out_cell_data     = out_data_r;
  assign out_cursor_row    = out_row_r;
  assign out_cursor_column = out_col_r;

endmodule

### src/text_console_writer_top.sv
// text console writer top level: command front, queue, back and the default attribute register
// depends on tcw_pkg, tcw_front, tcw_queue, tcw_back
//
// An 80 x 25 character-cell console. Commands are taken while busy is low into a two-word queue;
// busy rises only when that queue is full. Each command gives exactly one result word, shown for
// a single cycle with out_valid, which the receiver must take. An end_line blanks the rest of
// the row, one cell written per cycle, and a clear blanks every cell; a write_char or end_line
// that scrolls first moves the rows up: the single write port of the screen memory copies one
// cell per cycle and then blanks the bottom row.
// After reset a clearing pass fills the screen before the first command runs;
// commands may still be queued during it. The default attribute port is always ready.
module text_console_writer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_func,
  input  logic [7:0]                   in_char_code,
  input  logic [7:0]                   in_attr,
  input  logic [tcw_pkg::CELL_W-1:0]   in_cell_index,
  output logic                         out_valid,
  output logic [tcw_pkg::DATA_W-1:0]   out_cell_data,
  output logic [tcw_pkg::ROW_W-1:0]    out_cursor_row,
  output logic [tcw_pkg::COL_W-1:0]    out_cursor_column,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [7:0]                   cfg_default_attr
);

  logic           push, pop, q_empty, q_full;
  tcw_pkg::item_t push_item, pop_item;
  logic [7:0]     default_attr_r;

  assign busy      = q_full;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_attr_r <= tcw_pkg::RESET_ATTR;
    end else if (cfg_valid && cfg_ready) begin
      default_attr_r <= cfg_default_attr;
    end
  end

  tcw_front u_front (
    .start         (start),
    .busy          (q_full),
    .in_func       (in_func),
    .in_char_code  (in_char_code),
    .in_attr       (in_attr),
    .in_cell_index (in_cell_index),
    .push          (push),
    .push_item     (push_item)
  );

  tcw_queue #(
    .DEPTH (tcw_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  tcw_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .default_attr      (default_attr_r),
    .q_empty           (q_empty),
    .q_item            (pop_item),
    .q_pop             (pop),
    .out_valid         (out_valid),
    .out_cell_data     (out_cell_data),
    .out_cursor_row    (out_cursor_row),
    .out_cursor_column (out_cursor_column)
  );

endmodule
